FILE: sv/dual_channel_average_seg_display_macros.svh
// ----------------------------------------------------------------------------
// dual channel average seg display assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef DUAL_CHANNEL_AVERAGE_SEG_DISPLAY_MACROS_SVH
`define DUAL_CHANNEL_AVERAGE_SEG_DISPLAY_MACROS_SVH

// same-cycle implication
`define DCASD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcasd assertion failed");

// next-cycle implication
`define DCASD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcasd assertion failed");

`endif

FILE: sv/dcasd_pkg.sv
// ----------------------------------------------------------------------------
// dcasd_pkg
// types, constants and digit decoding for the averaging display block
// ----------------------------------------------------------------------------
`default_nettype none

package dcasd_pkg;

    localparam int SAMPLE_BITS  = 10;
    localparam int X8_W         = SAMPLE_BITS + 3;
    localparam int RECIP_W      = 13;
    localparam int RECIP_SHIFT  = 16;
    localparam int PROD_W       = X8_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_W'(4369);
    localparam logic [X8_W-1:0]    DIVISOR_15 = X8_W'(15);

    localparam int SUM_W        = 23;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam int COUNT_W      = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam int THRESH_W     = 12;
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(400);
    localparam int REM_W        = COUNT_W + 1;
    localparam int DIV_CNT_W    = $clog2(SUM_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

    localparam int SHOWN_W      = 10;
    localparam logic [SHOWN_W-1:0] SHOWN_MAX = '1;

    localparam int NUM_SLOTS    = 6;
    localparam int SLOT_W       = $clog2(NUM_SLOTS);
    localparam int HALF_SLOTS   = NUM_SLOTS / 2;
    localparam int SEG_W        = 8;

    localparam logic [1:0] PLACE_HUNDREDS = 2'd0;
    localparam logic [1:0] PLACE_TENS     = 2'd1;
    localparam logic [1:0] PLACE_ONES     = 2'd2;

    localparam logic [SEG_W-1:0] DP_MASK = 8'h80;
    localparam logic [SEG_W-1:0] GLYPH [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ACCUM,
        ST_CHECK,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_raw;
        logic show;
        logic scale;
        logic accum;
        logic div_load;
        logic div_step;
        logic div_finish;
    } cmd_t;

    typedef struct packed {
        logic out_blocked;
        logic avg_due;
        logic div_last;
    } status_t;

    function automatic logic [SEG_W-1:0] digit_pattern(
        input logic [SHOWN_W-1:0] value,
        input logic [1:0]         place
    );
        logic [SHOWN_W-1:0] v;
        logic [6:0]         rem;
        logic [3:0]         hund;
        logic [3:0]         tens;
        logic [3:0]         ones;
        logic [3:0]         d;
        logic [SEG_W-1:0]   dp;
        v = (value >= SHOWN_W'(1000)) ? value - SHOWN_W'(1000) : value;
        hund = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (v >= SHOWN_W'(k * 100))
            begin
                hund = 4'(k);
            end
        end
        rem = 7'(v - SHOWN_W'(int'(hund) * 100));
        tens = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (rem >= 7'(k * 10))
            begin
                tens = 4'(k);
            end
        end
        ones = 4'(rem - 7'(int'(tens) * 10));
        dp = 8'h00;
        unique case (place)
            PLACE_HUNDREDS: d = hund;
            PLACE_TENS:
            begin
                d  = tens;
                dp = DP_MASK;
            end
            default: d = ones;
        endcase
        return GLYPH[d] | dp;
    endfunction

endpackage

`default_nettype wire

FILE: sv/dual_channel_average_seg_display.sv
// ----------------------------------------------------------------------------
// dual_channel_average_seg_display
// two-channel averaging voltmeter driving a six-digit multiplexed display
// ----------------------------------------------------------------------------
// A scan tick (action = 1) yields one transaction on the output side: the
// segment byte and the active-low digit select for the next of six slots,
// held in an output register so that further input can be taken while it
// waits. A converter sample (action = 0) yields no output and occupies the
// block through its accept, reciprocal multiply, accumulate and threshold
// check steps. When the pair count passes the threshold the sample goes on:
// a 23-step restoring divider forms both channel averages side by side, one
// quotient bit per cycle, and a finish step then loads the shown values.
// Every input is held off while a sample is still in progress, and a tick
// is also held off while a previous result is still stalled at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_channel_average_seg_display
    import dcasd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   action,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic                   cfg_write,
    input  wire logic [THRESH_W-1:0]    cfg_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [SEG_W-1:0]            segments,
    output logic [NUM_SLOTS-1:0]        digit_enable_n
);

    cmd_t    cmd;
    status_t status;

    dcasd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    dcasd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .sample         (sample),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .segments       (segments),
        .digit_enable_n (digit_enable_n)
    );

endmodule

`default_nettype wire

FILE: sv/dcasd_ctrl.sv
// ----------------------------------------------------------------------------
// dcasd_ctrl
// sequencer for sample accumulation, averaging division and scan ticks
// ----------------------------------------------------------------------------
`default_nettype none

module dcasd_ctrl
    import dcasd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    action,
    output logic         in_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE) || (action && status.out_blocked);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !action)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:  state_next = ST_ACCUM;
            ST_ACCUM:  state_next = ST_CHECK;
            ST_CHECK:  state_next = status.avg_due ? ST_DIVIDE : ST_IDLE;
            ST_DIVIDE: state_next = status.div_last ? ST_FINISH : ST_DIVIDE;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_raw = accept && !action;
                cmd.show     = accept && action;
            end
            ST_SCALE:  cmd.scale      = 1'b1;
            ST_ACCUM:  cmd.accum      = 1'b1;
            ST_CHECK:  cmd.div_load   = status.avg_due;
            ST_DIVIDE: cmd.div_step   = 1'b1;
            ST_FINISH: cmd.div_finish = 1'b1;
            default:   cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/dcasd_datapath.sv
// ----------------------------------------------------------------------------
// dcasd_datapath
// scaling, channel sums, two-lane restoring divider and digit output register
// ----------------------------------------------------------------------------
`default_nettype none

module dcasd_datapath
    import dcasd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmd_t                   cmd,
    output status_t                     status,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic                   cfg_write,
    input  wire logic [THRESH_W-1:0]    cfg_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [SEG_W-1:0]            segments,
    output logic [NUM_SLOTS-1:0]        digit_enable_n
);

    logic [SAMPLE_BITS-1:0] raw_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [THRESH_W-1:0]    threshold_reg;
    logic                   channel_reg;
    logic [SUM_W-1:0]       sum_one_reg;
    logic [SUM_W-1:0]       sum_zero_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [SHOWN_W-1:0]     shown_first_reg;
    logic [SHOWN_W-1:0]     shown_second_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic                   out_valid_reg;
    logic [SEG_W-1:0]       segments_reg;
    logic [NUM_SLOTS-1:0]   digit_enable_n_reg;
    logic [SUM_W-1:0]       quo_one_reg;
    logic [SUM_W-1:0]       quo_zero_reg;
    logic [REM_W-1:0]       rem_one_reg;
    logic [REM_W-1:0]       rem_zero_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;

    logic [X8_W-1:0]        x8;
    logic [SAMPLE_BITS-1:0] q_est;
    logic [X8_W-1:0]        resid;
    logic [SAMPLE_BITS-1:0] scaled;
    logic [SUM_W:0]         sum_wide;
    logic [SUM_W-1:0]       sum_sat;
    logic [COUNT_W-1:0]     count_inc;

    logic [REM_W-1:0]       rem_one_shift;
    logic [REM_W-1:0]       rem_zero_shift;
    logic [REM_W-1:0]       divisor;
    logic                   ge_one;
    logic                   ge_zero;
    logic [SHOWN_W-1:0]     avg_one;
    logic [SHOWN_W-1:0]     avg_zero;

    logic [SLOT_W-1:0]      slot;
    logic [SHOWN_W-1:0]     value;
    logic [1:0]             place;
    logic [SLOT_W-1:0]      slot_next;

    // scaling by 8/15 with reciprocal estimate and one correction
    assign x8     = {raw_reg, 3'b000};
    assign q_est  = prod_reg[PROD_W-1 -: SAMPLE_BITS];
    assign resid  = x8 - (X8_W'({q_est, 4'b0000}) - X8_W'(q_est));
    assign scaled = q_est + SAMPLE_BITS'(resid >= DIVISOR_15);

    assign sum_wide  = {1'b0, (channel_reg ? sum_one_reg : sum_zero_reg)}
                     + (SUM_W + 1)'(scaled);
    assign sum_sat   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    // divider lanes
    assign divisor        = REM_W'(count_reg);
    assign rem_one_shift  = {rem_one_reg[REM_W-2:0], quo_one_reg[SUM_W-1]};
    assign rem_zero_shift = {rem_zero_reg[REM_W-2:0], quo_zero_reg[SUM_W-1]};
    assign ge_one         = rem_one_shift >= divisor;
    assign ge_zero        = rem_zero_shift >= divisor;
    assign avg_one  = (|quo_one_reg[SUM_W-1:SHOWN_W])  ? SHOWN_MAX : quo_one_reg[SHOWN_W-1:0];
    assign avg_zero = (|quo_zero_reg[SUM_W-1:SHOWN_W]) ? SHOWN_MAX : quo_zero_reg[SHOWN_W-1:0];

    // scan slot decode
    assign slot      = (slot_reg < SLOT_W'(NUM_SLOTS)) ? slot_reg : '0;
    assign value     = (slot < SLOT_W'(HALF_SLOTS)) ? shown_first_reg : shown_second_reg;
    assign place     = (slot < SLOT_W'(HALF_SLOTS)) ? 2'(slot) : 2'(slot - SLOT_W'(HALF_SLOTS));
    assign slot_next = (slot == SLOT_W'(NUM_SLOTS - 1)) ? '0 : slot + 1'b1;

    assign status.out_blocked = out_valid_reg && out_stall;
    assign status.avg_due     = count_reg > COUNT_W'(threshold_reg);
    assign status.div_last    = div_cnt_reg == DIV_LAST;

    assign out_valid      = out_valid_reg;
    assign segments       = segments_reg;
    assign digit_enable_n = digit_enable_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESH_RESET;
            channel_reg      <= 1'b1;
            sum_one_reg      <= '0;
            sum_zero_reg     <= '0;
            count_reg        <= '0;
            shown_first_reg  <= '0;
            shown_second_reg <= '0;
            slot_reg         <= '0;
            out_valid_reg    <= 1'b0;
            div_cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                threshold_reg <= cfg_data;
            end
            if (cmd.accum)
            begin
                channel_reg <= !channel_reg;
                if (channel_reg)
                begin
                    sum_one_reg <= sum_sat;
                end
                else
                begin
                    sum_zero_reg <= sum_sat;
                    count_reg    <= count_inc;
                end
            end
            if (cmd.div_load)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.div_finish)
            begin
                shown_first_reg  <= avg_one;
                shown_second_reg <= avg_zero;
                sum_one_reg      <= '0;
                sum_zero_reg     <= '0;
                count_reg        <= '0;
            end
            if (cmd.show)
            begin
                slot_reg      <= slot_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_raw)
        begin
            raw_reg <= sample;
        end
        if (cmd.scale)
        begin
            prod_reg <= PROD_W'(x8) * PROD_W'(RECIP_15);
        end
        if (cmd.div_load)
        begin
            quo_one_reg  <= sum_one_reg;
            quo_zero_reg <= sum_zero_reg;
            rem_one_reg  <= '0;
            rem_zero_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_one_reg  <= {quo_one_reg[SUM_W-2:0], ge_one};
            quo_zero_reg <= {quo_zero_reg[SUM_W-2:0], ge_zero};
            rem_one_reg  <= ge_one ? rem_one_shift - divisor : rem_one_shift;
            rem_zero_reg <= ge_zero ? rem_zero_shift - divisor : rem_zero_shift;
        end
        if (cmd.show)
        begin
            segments_reg       <= digit_pattern(value, place);
            digit_enable_n_reg <= ~(NUM_SLOTS'(1) << slot);
        end
    end

endmodule

`default_nettype wire

FILE: sv/dcasd_checker.sv
// ----------------------------------------------------------------------------
// dcasd_checker
// port-level checks for the averaging display block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_channel_average_seg_display_macros.svh"

module dcasd_checker
    import dcasd_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_stall,
    input wire logic                   action,
    input wire logic [SAMPLE_BITS-1:0] sample,
    input wire logic                   cfg_write,
    input wire logic [THRESH_W-1:0]    cfg_data,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic [SEG_W-1:0]       segments,
    input wire logic [NUM_SLOTS-1:0]   digit_enable_n
);

    // stalled result holds
    `DCASD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(segments) && $stable(digit_enable_n))

    // exactly one digit driven
    `DCASD_ASSERT_NOW(a_one_digit, out_valid, $onehot(~digit_enable_n))

    // decimal point only on the tens digits
    `DCASD_ASSERT_NOW(a_dp_tens, out_valid, segments[7] == (!digit_enable_n[1] || !digit_enable_n[4]))

    // a taken tick always shows a result next cycle
    `DCASD_ASSERT_NEXT(a_tick_result, in_valid && !in_stall && action, out_valid)

endmodule

bind dual_channel_average_seg_display dcasd_checker u_checker (.*);

`default_nettype wire

FILE: tb/tb_dual_channel_average_seg_display.sv
// ----------------------------------------------------------------------------
// tb_dual_channel_average_seg_display
// self-checking bench for the two-channel averaging voltmeter display
// ----------------------------------------------------------------------------
// Samples and scan ticks are pushed through the input channel. Each accepted
// transaction steps a local model of the channel sums, the pair counter, the
// shown values and the scan slot. Every tick queues the expected segment byte
// and digit select, which are compared in order with the output transactions.
// A directed table comes first (reset display, scan wrap, threshold zero,
// reading extremes). A short run under the largest threshold follows, then
// random phases under several thresholds, with random idle bursts on both
// sides and a quiet tail.
// ----------------------------------------------------------------------------

module tb_dual_channel_average_seg_display;
    import dcasd_pkg::*;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    localparam logic [SEG_W-1:0] DP_BIT = 8'h80;
    localparam int SETTLE_CYCLES = 40;
    localparam int TAIL_CYCLES   = 60;
    localparam int STALL_LIMIT   = 2000;
    localparam int NUM_ROWS      = 24;

    typedef struct packed {
        logic [SEG_W-1:0]     seg;
        logic [NUM_SLOTS-1:0] den;
    } disp_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_FIXED,
        ROW_THRESH
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic                 act;
        logic [THRESH_W-1:0]  value;
        logic [SEG_W-1:0]     seg;
        logic [NUM_SLOTS-1:0] den;
    } stim_row_t;

    localparam logic [SEG_W-1:0] SEG_FONT [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        // blank display after reset, all six slots and the wrap to slot 0
        '{ROW_FIXED,   ACT_TICK,   12'd0,    8'h3F, 6'h3E},
        '{ROW_FIXED,   ACT_TICK,   12'd0,    8'hBF, 6'h3D},
        '{ROW_FIXED,   ACT_TICK,   12'd0,    8'h3F, 6'h3B},
        '{ROW_FIXED,   ACT_TICK,   12'd0,    8'h3F, 6'h37},
        '{ROW_FIXED,   ACT_TICK,   12'd0,    8'hBF, 6'h2F},
        '{ROW_FIXED,   ACT_TICK,   12'd0,    8'h3F, 6'h1F},
        '{ROW_FIXED,   ACT_TICK,   12'd0,    8'h3F, 6'h3E},
        // threshold zero, first pair averages at full scale
        '{ROW_THRESH,  ACT_SAMPLE, 12'd0,    8'h00, 6'h00},
        '{ROW_PREDICT, ACT_SAMPLE, 12'd1023, 8'h00, 6'h00},
        '{ROW_PREDICT, ACT_SAMPLE, 12'd1023, 8'h00, 6'h00},
        '{ROW_PREDICT, ACT_TICK,   12'd0,    8'h00, 6'h00},
        '{ROW_PREDICT, ACT_TICK,   12'd0,    8'h00, 6'h00},
        '{ROW_PREDICT, ACT_TICK,   12'd0,    8'h00, 6'h00},
        // threshold one, two pairs with zero and full-scale readings
        '{ROW_THRESH,  ACT_SAMPLE, 12'd1,    8'h00, 6'h00},
        '{ROW_PREDICT, ACT_SAMPLE, 12'd0,    8'h00, 6'h00},
        '{ROW_PREDICT, ACT_SAMPLE, 12'd1023, 8'h00, 6'h00},
        '{ROW_PREDICT, ACT_SAMPLE, 12'd1023, 8'h00, 6'h00},
        '{ROW_PREDICT, ACT_SAMPLE, 12'd0,    8'h00, 6'h00},
        '{ROW_PREDICT, ACT_TICK,   12'd0,    8'h00, 6'h00},
        '{ROW_PREDICT, ACT_TICK,   12'd0,    8'h00, 6'h00},
        '{ROW_PREDICT, ACT_TICK,   12'd0,    8'h00, 6'h00},
        '{ROW_PREDICT, ACT_TICK,   12'd0,    8'h00, 6'h00},
        '{ROW_PREDICT, ACT_TICK,   12'd0,    8'h00, 6'h00},
        '{ROW_PREDICT, ACT_TICK,   12'd0,    8'h00, 6'h00}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   action = 1'b0;
    logic [SAMPLE_BITS-1:0] sample = '0;
    logic                   cfg_write = 1'b0;
    logic [THRESH_W-1:0]    cfg_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [SEG_W-1:0]       segments;
    logic [NUM_SLOTS-1:0]   digit_enable_n;

    // model state
    logic [THRESH_W-1:0] avg_threshold = THRESH_RESET;
    logic                chan_sel = 1'b1;
    logic [SUM_W-1:0]    sum_ch1 = '0;
    logic [SUM_W-1:0]    sum_ch0 = '0;
    logic [COUNT_W-1:0]  pair_cnt = '0;
    logic [SHOWN_W-1:0]  shown_ch1 = '0;
    logic [SHOWN_W-1:0]  shown_ch0 = '0;
    logic [2:0]          scan_pos = '0;

    disp_t expected_digits [$];
    int    fail_count = 0;
    int    quiet_cycles = 0;
    int    stall_left = 0;
    bit    allow_idle = 1'b1;

    dual_channel_average_seg_display u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .sample         (sample),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .segments       (segments),
        .digit_enable_n (digit_enable_n)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [SHOWN_W-1:0] channel_average(
        input logic [SUM_W-1:0]   sum,
        input logic [COUNT_W-1:0] count
    );
        int unsigned q;
        q = (count != '0) ? 32'(sum) / 32'(count) : 0;
        return (q > 32'(SHOWN_MAX)) ? SHOWN_MAX : SHOWN_W'(q);
    endfunction

    function automatic bit step_voltmeter(
        input  logic                   act,
        input  logic [SAMPLE_BITS-1:0] smp,
        output disp_t                  res
    );
        int unsigned scaled;
        int unsigned acc;
        int unsigned slot;
        int unsigned val;
        int unsigned d;
        logic [1:0]  place;
        res = '0;
        if (act == ACT_SAMPLE)
        begin
            scaled = (32'(smp) * 32'd24) / 32'd45;
            if (chan_sel)
            begin
                chan_sel = 1'b0;
                acc = 32'(sum_ch1) + scaled;
                sum_ch1 = (acc > 32'(SUM_MAX)) ? SUM_MAX : SUM_W'(acc);
            end
            else
            begin
                chan_sel = 1'b1;
                acc = 32'(sum_ch0) + scaled;
                sum_ch0 = (acc > 32'(SUM_MAX)) ? SUM_MAX : SUM_W'(acc);
                if (pair_cnt < COUNT_MAX)
                begin
                    pair_cnt = pair_cnt + 1'b1;
                end
            end
            if (pair_cnt > {1'b0, avg_threshold})
            begin
                shown_ch1 = channel_average(sum_ch1, pair_cnt);
                shown_ch0 = channel_average(sum_ch0, pair_cnt);
                pair_cnt = '0;
                sum_ch1 = '0;
                sum_ch0 = '0;
            end
            return 1'b0;
        end
        slot = (scan_pos < 3'(NUM_SLOTS)) ? 32'(scan_pos) : 0;
        val = (slot < 32'(HALF_SLOTS)) ? 32'(shown_ch1) : 32'(shown_ch0);
        place = 2'(slot % 32'(HALF_SLOTS));
        case (place)
            PLACE_HUNDREDS: d = (val % 1000) / 100;
            PLACE_TENS:     d = (val % 100) / 10;
            default:        d = val % 10;
        endcase
        res.seg = SEG_FONT[d] | ((place == PLACE_TENS) ? DP_BIT : '0);
        res.den = ~(NUM_SLOTS'(1) << slot);
        scan_pos = (slot + 1 >= 32'(NUM_SLOTS)) ? 3'd0 : 3'(slot + 1);
        return 1'b1;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic log_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic send_item(
        input logic                   act,
        input logic [SAMPLE_BITS-1:0] smp,
        input bit                     pinned,
        input logic [SEG_W-1:0]       pin_seg,
        input logic [NUM_SLOTS-1:0]   pin_den
    );
        disp_t res;
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            action   <= 1'($urandom);
            sample   <= SAMPLE_BITS'($urandom);
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        sample   <= smp;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (step_voltmeter(act, smp, res))
        begin
            if (pinned)
            begin
                res.seg = pin_seg;
                res.den = pin_den;
            end
            expected_digits.push_back(res);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_digits.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // only written with the block idle, once any averaging sample has finished
    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        avg_threshold = value;
    endtask

    // output side stall bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (allow_idle && rst_n && $urandom_range(0, 4) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : out_check
        disp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_digits.size() == 0)
            begin
                log_mismatch($sformatf("unexpected transaction seg=%h den=%h",
                                       segments, digit_enable_n));
            end
            else
            begin
                want = expected_digits.pop_front();
                if (segments !== want.seg)
                begin
                    log_mismatch($sformatf("segments expected %h actual %h",
                                           want.seg, segments));
                end
                if (digit_enable_n !== want.den)
                begin
                    log_mismatch($sformatf("digit_enable_n expected %h actual %h",
                                           want.den, digit_enable_n));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("dual_channel_average_seg_display test failed");
            $finish;
        end
    end

    initial
    begin
        int                  r;
        int                  ph;
        int                  i;
        logic                act;
        logic [THRESH_W-1:0] thr;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < NUM_ROWS; r++)
        begin
            case (DIRECTED[r].kind)
                ROW_THRESH:
                begin
                    write_threshold(DIRECTED[r].value);
                end
                ROW_FIXED:
                begin
                    send_item(DIRECTED[r].act, SAMPLE_BITS'(DIRECTED[r].value), 1'b1,
                              DIRECTED[r].seg, DIRECTED[r].den);
                end
                default:
                begin
                    send_item(DIRECTED[r].act, SAMPLE_BITS'(DIRECTED[r].value), 1'b0,
                              '0, '0);
                end
            endcase
        end

        // largest threshold, sums only build up during a short burst
        write_threshold('1);
        for (i = 0; i < 16; i++)
        begin
            send_item(ACT_SAMPLE, pick_sample(), 1'b0, '0, '0);
            if (i % 4 == 3)
            begin
                send_item(ACT_TICK, pick_sample(), 1'b0, '0, '0);
            end
        end
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            send_item(ACT_TICK, pick_sample(), 1'b0, '0, '0);
        end

        for (ph = 0; ph < 8; ph++)
        begin
            if (ph == 3)
            begin
                thr = '0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                thr = THRESH_W'($urandom_range(1, 40));
            end
            else
            begin
                thr = THRESH_W'($urandom_range(1, 6));
            end
            if (ph == 7)
            begin
                allow_idle = 1'b0;
            end
            write_threshold(thr);
            for (i = 0; i < 60; i++)
            begin
                if (ph == 2 && i == 30)
                begin
                    drain_results();
                end
                act = ($urandom_range(0, 9) < 4) ? ACT_TICK : ACT_SAMPLE;
                send_item(act, pick_sample(), 1'b0, '0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_digits.size() != 0)
        begin
            log_mismatch("transactions still expected at end of run");
        end
        if (fail_count == 0)
        begin
            $display("dual_channel_average_seg_display test passed");
        end
        else
        begin
            $display("dual_channel_average_seg_display test failed");
        end
        $finish;
    end

endmodule
